[rtl/core/itf_pkg.sv]
// Package: request, character and job types, conversion codes and character helpers.
`timescale 1ns / 1ps
`default_nettype none
package itf_pkg;

  localparam int MaxWidthDefault = 63;

  localparam logic [2:0] OP_SDEC = 3'd0;
  localparam logic [2:0] OP_UDEC = 3'd1;
  localparam logic [2:0] OP_HEX  = 3'd2;
  localparam logic [2:0] OP_OCT  = 3'd3;
  localparam logic [2:0] OP_CHAR = 3'd4;

  localparam logic [31:0] RecipTen = 32'hCCCC_CCCD;

  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChUpperA = 8'h41;

  typedef enum logic [1:0] {
    KIND_DEC  = 2'd0,
    KIND_HEX  = 2'd1,
    KIND_OCT  = 2'd2,
    KIND_CHAR = 2'd3
  } kind_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] value;
    logic [5:0]  field_width;
    logic        left_adjust;
    logic        zero_pad;
  } req_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last;
  } txt_t;

  typedef struct packed {
    kind_t       kind;
    logic        neg;
    logic [31:0] mag;
    logic [3:0]  len;
    logic [5:0]  width;
    logic        left;
    logic [7:0]  pad_char;
  } job_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = ChZero + {4'd0, d};
    end else begin
      c = ChUpperA + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[rtl/core/integer_to_text_formatter.sv]
// Top level: integer to ASCII field formatter.
//
//  channel | signals                    | moves
//  --------+----------------------------+-------------------------------------
//  req     | req_valid, req_stall, req  | one request: code, operand, width, flags
//  txt     | txt_valid, txt_stall, txt  | one character of the field, last flag
//
// A request is registered in the queue; the back end takes it once it is idle.
// Decimal codes make one digit (1 to 10 digits) per step of the divide-by-ten loop.
// Then max(width, text length) characters leave, one per cycle unless txt stalls.
// Unused codes are taken and dropped with no characters.
// Reset (rst, synchronous) empties the queue and the output register.
// A stall on txt holds the character; the queue keeps taking up to two requests.
`timescale 1ns / 1ps
`default_nettype none
module integer_to_text_formatter import itf_pkg::*; #(
  parameter int MAX_WIDTH = MaxWidthDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic txt_valid,
  input  logic txt_stall,
  output txt_t txt
);

  logic push_valid;
  logic push_stall;
  job_t push_job;
  logic pop_valid;
  logic pop_stall;
  job_t pop_job;

  itf_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .push_valid(push_valid),
    .push_stall(push_stall),
    .job       (push_job)
  );

  itf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_stall(push_stall),
    .push_job  (push_job),
    .pop_valid (pop_valid),
    .pop_stall (pop_stall),
    .pop_job   (pop_job)
  );

  itf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_valid(pop_valid),
    .pop_stall(pop_stall),
    .pop_job  (pop_job),
    .txt_valid(txt_valid),
    .txt_stall(txt_stall),
    .txt      (txt)
  );

endmodule
`default_nettype wire

[rtl/core/itf_front.sv]
// Front end: accept requests, drop unused codes, saturate width, size hex/octal text.
`timescale 1ns / 1ps
`default_nettype none
module itf_front import itf_pkg::*; #(
  parameter int MAX_WIDTH = MaxWidthDefault
) (
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic push_valid,
  input  logic push_stall,
  output job_t job
);

  localparam logic [5:0] WidthCap = 6'(MAX_WIDTH);

  logic       op_ok;
  logic [3:0] hex_len;
  logic [3:0] oct_len;

  always_comb begin
    hex_len = 4'd1;
    for (int i = 1; i < 8; i++) begin
      if (req.value[4*i +: 4] != 4'd0) begin
        hex_len = 4'(i + 1);
      end
    end
    oct_len = 4'd1;
    for (int j = 1; j < 10; j++) begin
      if (req.value[3*j +: 3] != 3'd0) begin
        oct_len = 4'(j + 1);
      end
    end
    if (req.value[31:30] != 2'd0) begin
      oct_len = 4'd11;
    end
  end

  always_comb begin
    op_ok        = 1'b1;
    job.kind     = KIND_DEC;
    job.neg      = 1'b0;
    job.mag      = req.value;
    job.len      = 4'd1;
    job.width    = (req.field_width > WidthCap) ? WidthCap : req.field_width;
    job.left     = req.left_adjust;
    job.pad_char = req.zero_pad ? ChZero : ChSpace;
    unique case (req.opcode)
      OP_SDEC: begin
        job.neg = req.value[31];
        if (req.value[31]) begin
          job.mag = 32'd0 - req.value;
        end
      end
      OP_UDEC: begin
        job.kind = KIND_DEC;
      end
      OP_HEX: begin
        job.kind = KIND_HEX;
        job.len  = hex_len;
      end
      OP_OCT: begin
        job.kind = KIND_OCT;
        job.len  = oct_len;
      end
      OP_CHAR: begin
        job.kind = KIND_CHAR;
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

  assign push_valid = req_valid && op_ok;
  assign req_stall  = op_ok && push_stall;

endmodule
`default_nettype wire

[rtl/core/itf_queue.sv]
// Two-entry job queue between front end and back end.
`timescale 1ns / 1ps
`default_nettype none
module itf_queue import itf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_stall,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_stall,
  output job_t pop_job
);

  job_t       slot [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_stall = (count == 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_job    = slot[rd_ptr];
  assign do_push    = push_valid && !push_stall;
  assign do_pop     = pop_valid && !pop_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_job;
    end
  end

endmodule
`default_nettype wire

[rtl/core/itf_back.sv]
// Back end: decimal digit conversion, padding and character output register.
`timescale 1ns / 1ps
`default_nettype none
module itf_back import itf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic pop_valid,
  output logic pop_stall,
  input  job_t pop_job,
  output logic txt_valid,
  input  logic txt_stall,
  output txt_t txt
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t      state;
  state_t      state_next;
  kind_t       kind;
  logic        neg;
  logic [31:0] mag;
  logic [3:0]  len;
  logic [5:0]  width;
  logic        left;
  logic [7:0]  pad_char;
  logic [3:0]  rev [0:9];
  logic [3:0]  ndig;
  logic [5:0]  k;

  logic        load_job;
  logic        conv_step;
  logic        emit_step;
  logic        out_free;

  logic [63:0] prod;
  logic [28:0] quo;
  logic [31:0] rem32;

  logic [5:0]  len6;
  logic [5:0]  total;
  logic [5:0]  extra;
  logic        in_text;
  logic [5:0]  t6;
  logic [3:0]  pos;
  logic [3:0]  hex_dig [0:7];
  logic [2:0]  oct_dig [0:10];
  logic [7:0]  text_ch;
  logic [7:0]  out_ch;
  logic        out_last;

  assign out_free  = !txt_valid || !txt_stall;
  assign pop_stall = (state != ST_IDLE);
  assign load_job  = (state == ST_IDLE) && pop_valid;
  assign conv_step = (state == ST_CONV);
  assign emit_step = (state == ST_EMIT) && out_free;

  always_comb begin
    prod  = {32'd0, mag} * {32'd0, RecipTen};
    quo   = prod[63:35];
    rem32 = mag - ({quo, 3'b000} + {2'b00, quo, 1'b0});
  end

  always_comb begin
    len6     = {2'd0, len};
    total    = (width > len6) ? width : len6;
    extra    = total - len6;
    in_text  = left ? (k < len6) : (k >= extra);
    t6       = left ? k : (k - extra);
    pos      = len - 4'd1 - t6[3:0];
    out_last = (k == total - 6'd1);
    for (int i = 0; i < 8; i++) begin
      hex_dig[i] = mag[4*i +: 4];
    end
    for (int j = 0; j < 10; j++) begin
      oct_dig[j] = mag[3*j +: 3];
    end
    oct_dig[10] = {1'b0, mag[31:30]};
    unique case (kind)
      KIND_DEC:  text_ch = (neg && (t6 == 6'd0)) ? ChMinus : digit_char(rev[pos]);
      KIND_HEX:  text_ch = digit_char(hex_dig[pos[2:0]]);
      KIND_OCT:  text_ch = digit_char({1'b0, oct_dig[pos]});
      KIND_CHAR: text_ch = mag[7:0];
      default:   text_ch = mag[7:0];
    endcase
    out_ch = in_text ? text_ch : pad_char;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pop_valid) begin
          state_next = (pop_job.kind == KIND_DEC) ? ST_CONV : ST_EMIT;
        end
      end
      ST_CONV: begin
        if (quo == 29'd0) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free && out_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      txt_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_step) begin
        txt_valid <= 1'b1;
      end else if (!txt_stall) begin
        txt_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_job) begin
      kind     <= pop_job.kind;
      neg      <= pop_job.neg;
      mag      <= pop_job.mag;
      len      <= pop_job.len;
      width    <= pop_job.width;
      left     <= pop_job.left;
      pad_char <= pop_job.pad_char;
      ndig     <= 4'd0;
      k        <= 6'd0;
    end
    if (conv_step) begin
      rev[ndig] <= rem32[3:0];
      ndig      <= ndig + 4'd1;
      mag       <= {3'd0, quo};
      if (quo == 29'd0) begin
        len <= ndig + 4'd1 + {3'd0, neg};
      end
    end
    if (emit_step) begin
      txt.text_char <= out_ch;
      txt.last      <= out_last;
      k             <= k + 6'd1;
    end
  end

endmodule
`default_nettype wire
